// ----- hw/rtl/png_scanline_unfilter_assert.svh -----
// Assertion macros shared by the unfilter RTL.
// Each macro takes a label, the clock, the active-low reset and the condition(s).
`ifndef PNG_SCANLINE_UNFILTER_ASSERT_SVH
`define PNG_SCANLINE_UNFILTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define PSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");
`define PSU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define PSU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PSU_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ----- hw/rtl/psu_pkg.sv -----
package psu_pkg;

    // Default maximum row width in pixels
    localparam int MAX_WIDTH_DEF = 4096;

    // Depth of the command queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Register map (word index into the APB space)
    localparam int        APB_AW     = 4;
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_ALPHA  = 2'd2;

    // Row filter types
    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_SUB   = 3'd1;
    localparam logic [2:0] FLT_UP    = 3'd2;
    localparam logic [2:0] FLT_AVG   = 3'd3;
    localparam logic [2:0] FLT_PAETH = 3'd4;

    // Last channel index of a pixel
    localparam logic [1:0] CHAN_LAST_RGB  = 2'd2;
    localparam logic [1:0] CHAN_LAST_RGBA = 2'd3;

    // One classified word handed from front to back
    typedef struct packed {
        logic [7:0] data;       // filtered sample byte
        logic [2:0] filter;     // filter type of the row
        logic [1:0] chan;       // channel within the pixel
        logic       first_px;   // first pixel of the row: no left, no upper-left
        logic       first_row;  // first row of the image: no up, no upper-left
        logic       last;       // closes the last pixel of the image
        logic       emit;       // closes a pixel: send a result
        logic       bad;        // bad filter type: send the error result
    } t_cmd;

    // Paeth predictor, distances kept non-negative
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic [8:0] ab;
        logic [8:0] cc;
        logic [8:0] pa;
        logic [8:0] pb;
        logic [8:0] pc;
        ab = {1'b0, a} + {1'b0, b};
        cc = {c, 1'b0};
        pa = (b > c) ? {1'b0, b - c} : {1'b0, c - b};
        pb = (a > c) ? {1'b0, a - c} : {1'b0, c - a};
        pc = (ab > cc) ? (ab - cc) : (cc - ab);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/psu_fifo.sv -----
`include "png_scanline_unfilter_assert.svh"

module psu_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PW = $clog2(psu_pkg::FIFO_DEPTH);
    localparam int CW = $clog2(psu_pkg::FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [psu_pkg::FIFO_DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_empty = (r_cnt == CW'(0));
    assign o_full  = (r_cnt == CW'(psu_pkg::FIFO_DEPTH));
    assign o_rdata = r_mem[r_rd];

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(psu_pkg::FIFO_DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(psu_pkg::FIFO_DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    `PSU_ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, i_push && o_full && !i_pop)
    `PSU_ASSERT_NEVER(a_no_underflow, i_clk, i_rst_n, i_pop && o_empty)

endmodule

// ----- hw/rtl/psu_front.sv -----
`include "png_scanline_unfilter_assert.svh"

module psu_front #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH * 4)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    output logic               o_ready,
    input  logic               i_fifo_full,
    input  logic [12:0]        i_width,
    input  logic [15:0]        i_height,
    input  logic               i_has_alpha,
    output logic               o_push,
    output psu_pkg::t_cmd      o_cmd,
    output logic [AW-1:0]      o_idx
);

    localparam int LW = $clog2(MAX_WIDTH * 4 + 1);

    logic [AW-1:0] r_col,     n_col;
    logic [15:0]   r_row,     n_row;
    logic [1:0]    r_chan,    n_chan;
    logic          r_first,   n_first;
    logic          r_expect,  n_expect;
    logic          r_discard, n_discard;
    logic [2:0]    r_filter,  n_filter;

    logic          accept;
    logic          over;
    logic [LW-1:0] w_eff;
    logic [LW-1:0] row_len;
    logic [15:0]   rows;
    logic          end_row;
    logic          last_row;
    logic [1:0]    chan_last;

    assign o_ready = !i_fifo_full;
    assign accept  = i_valid && o_ready;

    // Clamp the geometry and derive the row length in bytes
    always_comb begin
        over = {4'd0, i_width} > 17'(MAX_WIDTH);
        if (i_width == 13'd0) begin
            w_eff = LW'(1);
        end else if (over) begin
            w_eff = LW'(MAX_WIDTH);
        end else begin
            w_eff = LW'(i_width);
        end
        row_len   = i_has_alpha ? (w_eff << 2) : ((w_eff << 1) + w_eff);
        rows      = (i_height == 16'd0) ? 16'd1 : i_height;
        chan_last = i_has_alpha ? psu_pkg::CHAN_LAST_RGBA : psu_pkg::CHAN_LAST_RGB;
        end_row   = (LW'(r_col) + LW'(1)) >= row_len;
        last_row  = ({1'b0, r_row} + 17'd1) >= {1'b0, rows};
    end

    // Classify the word and advance the row position
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_chan    = r_chan;
        n_first   = r_first;
        n_expect  = r_expect;
        n_discard = r_discard;
        n_filter  = r_filter;
        o_push    = 1'b0;
        o_cmd     = '0;
        o_idx     = r_col;
        if (accept) begin
            if (r_expect) begin
                n_expect = 1'b0;
                n_col    = '0;
                n_chan   = '0;
                n_first  = 1'b1;
                if (!r_discard) begin
                    if (i_byte > 8'(psu_pkg::FLT_PAETH)) begin
                        n_discard = 1'b1;
                        o_push    = 1'b1;
                        o_cmd.bad = 1'b1;
                    end else begin
                        n_filter = i_byte[2:0];
                    end
                end
            end else begin
                if (!r_discard) begin
                    o_push          = 1'b1;
                    o_cmd.data      = i_byte;
                    o_cmd.filter    = r_filter;
                    o_cmd.chan      = r_chan;
                    o_cmd.first_px  = r_first;
                    o_cmd.first_row = (r_row == 16'd0);
                    o_cmd.last      = end_row && last_row;
                    o_cmd.emit      = (r_chan == chan_last);
                end
                n_col = r_col + AW'(1);
                if (r_chan == chan_last) begin
                    n_chan  = '0;
                    n_first = 1'b0;
                end else begin
                    n_chan = r_chan + 2'd1;
                end
                if (end_row) begin
                    n_col    = '0;
                    n_expect = 1'b1;
                    if (last_row) begin
                        n_row     = '0;
                        n_discard = 1'b0;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end
            end
        end
    end

    // Hold the row position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_chan    <= '0;
            r_first   <= 1'b1;
            r_expect  <= 1'b1;
            r_discard <= 1'b0;
            r_filter  <= psu_pkg::FLT_NONE;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_chan    <= n_chan;
            r_first   <= n_first;
            r_expect  <= n_expect;
            r_discard <= n_discard;
            r_filter  <= n_filter;
        end
    end

    `PSU_ASSERT_IMP(a_quiet_discard, i_clk, i_rst_n, r_discard, !o_push)
    `PSU_ASSERT_IMP(a_push_accepted, i_clk, i_rst_n, o_push, accept)

endmodule

// ----- hw/rtl/psu_back.sv -----
`include "png_scanline_unfilter_assert.svh"

module psu_back #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF,
    parameter int AW        = $clog2(MAX_WIDTH * 4)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  psu_pkg::t_cmd i_cmd,
    input  logic [AW-1:0] i_idx,
    output logic          o_pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [23:0]   m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic          m_axis_tlast,
    output logic          m_axis_tuser    // bad_filter
);

    localparam int ROW_DEPTH = MAX_WIDTH * 4;

    logic [7:0]    r_line [ROW_DEPTH];
    logic          r_a_valid;
    psu_pkg::t_cmd r_a_cmd;
    logic [AW-1:0] r_a_idx;
    logic [7:0]    r_up;
    logic [7:0]    r_left   [4];
    logic [7:0]    r_upleft [4];
    logic [23:0]   r_hold,  n_hold;
    logic          r_m_valid;
    logic [23:0]   r_m_data;
    logic          r_m_last;
    logic          r_m_user;

    logic          out_free;
    logic          a_adv;
    logic          wr_en;
    logic [7:0]    left;
    logic [7:0]    up;
    logic [7:0]    upleft;
    logic [7:0]    pred;
    logic [8:0]    avg_sum;
    logic [7:0]    val;

    assign out_free = !r_m_valid || m_axis_tready;
    assign a_adv    = r_a_valid && (!(r_a_cmd.emit || r_a_cmd.bad) || out_free);
    assign o_pop    = !i_empty && (!r_a_valid || a_adv);
    assign wr_en    = a_adv && !r_a_cmd.bad;

    // Rebuild the byte from its neighbors
    always_comb begin
        left    = r_a_cmd.first_px ? 8'd0 : r_left[r_a_cmd.chan];
        up      = r_a_cmd.first_row ? 8'd0 : r_up;
        upleft  = (r_a_cmd.first_row || r_a_cmd.first_px) ? 8'd0 : r_upleft[r_a_cmd.chan];
        avg_sum = {1'b0, left} + {1'b0, up};
        case (r_a_cmd.filter)
            psu_pkg::FLT_SUB:   pred = left;
            psu_pkg::FLT_UP:    pred = up;
            psu_pkg::FLT_AVG:   pred = avg_sum[8:1];
            psu_pkg::FLT_PAETH: pred = psu_pkg::paeth(left, up, upleft);
            default:            pred = 8'd0;
        endcase
        val    = r_a_cmd.data + pred;
        n_hold = r_hold;
        case (r_a_cmd.chan)
            2'd0:    n_hold[7:0]   = val;
            2'd1:    n_hold[15:8]  = val;
            2'd2:    n_hold[23:16] = val;
            default: n_hold        = r_hold;
        endcase
    end

    // Read the line store as the word leaves the queue
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_up    <= r_line[i_idx];
            r_a_cmd <= i_cmd;
            r_a_idx <= i_idx;
        end
    end

    // Write back the rebuilt byte and the neighbor history
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_line[r_a_idx]          <= val;
            r_left[r_a_cmd.chan]     <= val;
            r_upleft[r_a_cmd.chan]   <= up;
            r_hold                   <= n_hold;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (a_adv && (r_a_cmd.emit || r_a_cmd.bad)) begin
            r_m_data <= r_a_cmd.bad ? 24'd0 : n_hold;
            r_m_last <= r_a_cmd.bad || r_a_cmd.last;
            r_m_user <= r_a_cmd.bad;
        end
    end

    // Track stage and output occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv && (r_a_cmd.emit || r_a_cmd.bad)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

    `PSU_ASSERT_IMP(a_error_shape, i_clk, i_rst_n, r_m_valid && r_m_user,
                    r_m_data == 24'd0 && r_m_last)
    `PSU_ASSERT_IMP(a_stage_holds, i_clk, i_rst_n, r_a_valid && !a_adv,
                    !o_pop)

endmodule

// ----- hw/rtl/png_scanline_unfilter.sv -----
// PNG scanline unfilter: rebuilds 8-bit RGB/RGBA rows from an inflated stream.
// Input (s_axis): one stream byte per word; each row opens with its filter-type byte
// (none, sub, up, average, Paeth), then width * 3 or 4 filtered sample bytes.
// Output (m_axis): one word per pixel, tdata = {blue, green, red}, alpha dropped;
// tlast marks the final pixel of an image, tuser marks a bad filter type (>4). The
// error word carries zero colors and tlast; the rest of that image is swallowed.
// Configuration (APB): 0x0 image_width, 0x4 image_height, 0x8 has_alpha; write
// only while the block is idle.
// Throughput: one byte per cycle while the receiver does not stall; the line store takes one read
// as a word leaves the queue and one write as it is rebuilt. A closing byte passes through the
// queue, the rebuild stage register and the output register before its result shows.
// A four-word queue parts the classifying front from the rebuild stage; when the
// receiver stalls, the output register, rebuild stage and queue fill and then
// s_axis_tready drops. Reset empties queue and pipeline, clears the row counters
// and loads width 1, height 1, RGB. The line store is not cleared: rows after the
// first read only entries written by the row above.
module png_scanline_unfilter #(
    parameter int MAX_WIDTH = psu_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // filtered_byte [7:0]
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    output logic                        m_axis_tlast,   // last_pixel
    output logic                        m_axis_tuser,   // bad_filter
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psu_pkg::APB_AW-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_WIDTH * 4);
    localparam int CW = $bits(psu_pkg::t_cmd);
    localparam int FW = CW + AW;

    logic [12:0]   r_width;
    logic [15:0]   r_height;
    logic          r_alpha;
    logic          cfg_wr;

    logic          push;
    psu_pkg::t_cmd f_cmd;
    logic [AW-1:0] f_idx;
    logic          fifo_full;
    logic          fifo_empty;
    logic          pop;
    logic [FW-1:0] q_rdata;

    // Register writes and reads
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd1;
            r_height <= 16'd1;
            r_alpha  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                psu_pkg::REG_WIDTH:  r_width  <= pwdata[12:0];
                psu_pkg::REG_HEIGHT: r_height <= pwdata[15:0];
                psu_pkg::REG_ALPHA:  r_alpha  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            psu_pkg::REG_WIDTH:  prdata = {19'd0, r_width};
            psu_pkg::REG_HEIGHT: prdata = {16'd0, r_height};
            psu_pkg::REG_ALPHA:  prdata = {31'd0, r_alpha};
            default:             prdata = 32'd0;
        endcase
    end

    psu_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_byte      (s_axis_tdata),
        .o_ready     (s_axis_tready),
        .i_fifo_full (fifo_full),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_has_alpha (r_alpha),
        .o_push      (push),
        .o_cmd       (f_cmd),
        .o_idx       (f_idx)
    );

    psu_fifo #(
        .WIDTH (FW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata ({f_idx, f_cmd}),
        .i_pop   (pop),
        .o_rdata (q_rdata),
        .o_empty (fifo_empty),
        .o_full  (fifo_full)
    );

    psu_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (fifo_empty),
        .i_cmd         (psu_pkg::t_cmd'(q_rdata[CW-1:0])),
        .i_idx         (q_rdata[FW-1:CW]),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import psu_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int ROW_DEPTH     = MAX_W * 4;
    localparam int RAND_ITEMS    = 650;
    localparam int SETTLE_CYCLES = 10;
    localparam int STALL_LIMIT   = 5000;
    localparam int MAX_REPORTS   = 40;

    // Filter-type bytes outside the defined set
    localparam logic [7:0] FLT_BAD_LOW = 8'd5;
    localparam logic [7:0] FLT_BAD_TOP = 8'hFF;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       bad_filter;
        logic       last_pixel;
    } pixel_t;

    typedef enum {RX_OPEN, RX_COIN, RX_CHOKE, RX_PERIODIC} rx_mode_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = '0;   // filtered_byte [7:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [23:0]         m_axis_tdata;        // red [7:0], green [15:8], blue [23:16]
    logic                m_axis_tlast;        // last_pixel
    logic                m_axis_tuser;        // bad_filter
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [APB_AW-1:0]   paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    png_scanline_unfilter #(.MAX_WIDTH(MAX_W)) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // Stream bytes waiting to be sent and pixels still owed by the block
    logic [7:0] stream_q [$];
    pixel_t     pixel_q [$];

    // Shadow of the configuration registers
    logic [12:0] cfg_width = 13'd1;
    logic [15:0] cfg_height = 16'd1;
    logic        cfg_alpha = 1'b0;

    // Unfilter state mirrored from the block
    logic [7:0]  line_store [0:ROW_DEPTH-1];
    logic [7:0]  left_px [4] = '{default: 8'd0};
    logic [7:0]  upleft_px [4] = '{default: 8'd0};
    logic [7:0]  hold_px [3] = '{default: 8'd0};
    logic [2:0]  row_filter = FLT_NONE;
    int unsigned byte_col = 0;
    int unsigned row_idx = 0;
    logic        want_filter = 1'b1;
    logic        skipping = 1'b0;

    int err_cnt = 0;
    int words_checked = 0;
    int bad_words = 0;
    int images = 0;
    int bytes_sent = 0;
    int reg_writes = 0;

    function automatic int unsigned eff_row_len();
        int unsigned w;
        w = cfg_width;
        if (w == 0) w = 1;
        if (w > MAX_W) w = MAX_W;
        return w * (cfg_alpha ? 4 : 3);
    endfunction

    function automatic int unsigned eff_rows();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int p;
        int da;
        int db;
        int dc;
        p  = int'(a) + int'(b) - int'(c);
        da = p - int'(a);
        db = p - int'(b);
        dc = p - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
    endfunction

    // Rebuild one stream byte and queue the pixel it closes, if any
    function automatic void unfilter_byte(input logic [7:0] b);
        int unsigned row_len;
        int unsigned rows;
        int unsigned ch;
        int unsigned chan;
        logic [7:0]  lf;
        logic [7:0]  up;
        logic [7:0]  ul;
        logic [7:0]  pred;
        logic [7:0]  val;
        logic        end_row;
        logic        last_row;
        pixel_t      px;
        row_len = eff_row_len();
        rows    = eff_rows();
        ch      = cfg_alpha ? 4 : 3;

        // Row start: take the filter type or flag a bad one
        if (want_filter) begin
            want_filter = 1'b0;
            byte_col = 0;
            foreach (left_px[k]) begin
                left_px[k] = 8'd0;
                upleft_px[k] = 8'd0;
            end
            foreach (hold_px[k]) hold_px[k] = 8'd0;
            if (skipping) return;
            if (b > 8'(FLT_PAETH)) begin
                skipping = 1'b1;
                px = '{red: 8'd0, green: 8'd0, blue: 8'd0, bad_filter: 1'b1, last_pixel: 1'b1};
                pixel_q.push_back(px);
                bad_words++;
                return;
            end
            row_filter = b[2:0];
            return;
        end

        if (!skipping) begin
            end_row  = (byte_col + 1 >= row_len);
            last_row = (row_idx + 1 >= rows);
            chan = byte_col % ch;
            lf = (byte_col < ch) ? 8'd0 : left_px[chan];
            up = (row_idx == 0) ? 8'd0 : line_store[byte_col];
            ul = (row_idx == 0 || byte_col < ch) ? 8'd0 : upleft_px[chan];
            case (row_filter)
                FLT_SUB:   pred = lf;
                FLT_UP:    pred = up;
                FLT_AVG:   pred = 8'((int'(lf) + int'(up)) >> 1);
                FLT_PAETH: pred = paeth_pick(lf, up, ul);
                default:   pred = 8'd0;
            endcase
            val = b + pred;
            line_store[byte_col] = val;
            left_px[chan] = val;
            upleft_px[chan] = up;
            if (chan < 3) hold_px[chan] = val;
            if (chan == ch - 1) begin
                px = '{red: hold_px[0], green: hold_px[1], blue: hold_px[2],
                       bad_filter: 1'b0, last_pixel: end_row && last_row};
                pixel_q.push_back(px);
            end
        end

        // Advance column; wrap row and image
        byte_col++;
        if (byte_col >= row_len) begin
            byte_col = 0;
            want_filter = 1'b1;
            if (row_idx + 1 >= rows) begin
                row_idx = 0;
                skipping = 1'b0;
            end else begin
                row_idx++;
            end
        end
    endfunction

    // Queue one row: filter byte, then random samples with extremes mixed in
    function automatic int push_row(input logic [7:0] flt);
        int unsigned len;
        int unsigned sel;
        len = eff_row_len();
        stream_q.push_back(flt);
        for (int k = 0; k < len; k++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) stream_q.push_back(8'h00);
            else if (sel == 1) stream_q.push_back(8'hFF);
            else stream_q.push_back(8'($urandom));
        end
        return len + 1;
    endfunction

    function automatic int queue_rows(input int unsigned nrows, input int bad_row);
        int n;
        logic [7:0] flt;
        n = 0;
        for (int r = 0; r < nrows; r++) begin
            if (r == bad_row) begin
                case ($urandom_range(0, 2))
                    0:       flt = FLT_BAD_LOW;
                    1:       flt = FLT_BAD_TOP;
                    default: flt = 8'($urandom_range(FLT_BAD_LOW, FLT_BAD_TOP));
                endcase
            end else begin
                flt = 8'($urandom_range(FLT_NONE, FLT_PAETH));
            end
            n += push_row(flt);
        end
        return n;
    endfunction

    // Wait until every byte is in and every pixel is out, then let the pipe settle
    task automatic wait_drained();
        do @(negedge i_clk);
        while (stream_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_WIDTH:  cfg_width = val[12:0];
            REG_HEIGHT: cfg_height = val[15:0];
            REG_ALPHA:  cfg_alpha = val[0];
            default:    ;
        endcase
        reg_writes++;
        @(negedge i_clk);
    endtask

    task automatic set_format(input int unsigned w, input int unsigned h, input bit a);
        wait_drained();
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_ALPHA, a);
    endtask

    // Sender: bursts of random length, random gaps, now and then a full drain
    int burst_left = 0;
    int gap_left = 0;
    int drain_wait = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
            drain_wait = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (burst_left == 0 && gap_left == 0 && drain_wait == 0) begin
                burst_left = $urandom_range(1, 48);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 39) == 0) drain_wait = 2;
            end
            if (drain_wait == 2) begin
                drain_wait = 1;
                s_axis_tvalid <= 1'b0;
            end else if (drain_wait == 1) begin
                if (pixel_q.size() == 0) drain_wait = 0;
                s_axis_tvalid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (stream_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= stream_q.pop_front();
                burst_left--;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches between open, coin-flip, choked and periodic
    rx_mode_t rx_mode = RX_OPEN;
    int rx_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_left = 0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:  m_axis_tready <= 1'b1;
                RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
                RX_CHOKE: m_axis_tready <= ($urandom_range(0, 4) == 0);
                default:  m_axis_tready <= ((rx_left % 7) > 1);
            endcase
        end
    end

    // Check each output word against the oldest pixel, then predict from the input word
    pixel_t got;
    pixel_t want;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{red: m_axis_tdata[7:0], green: m_axis_tdata[15:8],
                        blue: m_axis_tdata[23:16], bad_filter: m_axis_tuser,
                        last_pixel: m_axis_tlast};
                words_checked++;
                if (pixel_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                        $display("%0t: unexpected word: expected none, got rgb=%02x %02x %02x bad=%0b last=%0b",
                                 $time, got.red, got.green, got.blue, got.bad_filter,
                                 got.last_pixel);
                end else begin
                    want = pixel_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.bad_filter !== want.bad_filter ||
                        got.last_pixel !== want.last_pixel) begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                            $display("%0t: pixel mismatch: expected rgb=%02x %02x %02x bad=%0b last=%0b, got rgb=%02x %02x %02x bad=%0b last=%0b",
                                     $time, want.red, want.green, want.blue, want.bad_filter,
                                     want.last_pixel, got.red, got.green, got.blue,
                                     got.bad_filter, got.last_pixel);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                unfilter_byte(s_axis_tdata);
                bytes_sent++;
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: watchdog: no traffic for %0d cycles, %0d pixels outstanding",
                     $time, quiet_cycles, pixel_q.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    int unsigned w;
    int unsigned h;
    int rand_items = 0;
    int rounds = 0;
    int bad_row;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset format 1x1 RGB: sub filter on the first pixel, extreme samples
        stream_q.push_back(8'(FLT_SUB));
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(8'h80);
        images++;

        // Zero width and height clamp to 1; RGBA drops alpha; bad filter discards
        set_format(0, 0, 1'b1);
        void'(push_row(8'(FLT_NONE)));
        void'(push_row(FLT_BAD_TOP));
        images += 2;

        // Small RGB image: up on the first row, then Paeth and average
        set_format(2, 3, 1'b0);
        void'(push_row(8'(FLT_UP)));
        void'(push_row(8'(FLT_PAETH)));
        void'(push_row(8'(FLT_AVG)));
        images++;

        // Random images, mostly small
        while (rand_items < RAND_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                w = $urandom_range(7, 24);
                h = $urandom_range(1, 2);
            end else begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 4);
            end
            set_format(w, h, 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 3)) begin
                bad_row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, h - 1) : -1;
                rand_items += queue_rows(eff_rows(), bad_row);
                images++;
            end
            rounds++;

            // Tallest image, cut short by lowering the height between rows
            if (rounds == 4) begin
                set_format(3, 16'hFFFF, 1'($urandom_range(0, 1)));
                void'(queue_rows(3, -1));
                wait_drained();
                reg_write(REG_HEIGHT, 32'd1);
                void'(queue_rows(1, -1));
                images++;
            end
        end

        // Full line store: oversized width clamps, second row reads every entry
        set_format(13'h1FFF, 2, 1'b1);
        void'(queue_rows(2, -1));
        set_format(MAX_W, 1, 1'b0);
        void'(queue_rows(1, -1));
        images += 2;

        wait_drained();
        $display("Sent %0d bytes in %0d images over %0d register writes;",
                 bytes_sent, images, reg_writes);
        $display("checked %0d output words, %0d of them bad-filter errors, %0d mismatches.",
                 words_checked, bad_words, err_cnt);
        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
